// ===== sv/dfpc_pkg.sv =====
package dfpc_pkg;
  localparam int MaxSlots = 32;
  localparam int CfgW = 6;
  localparam int RealW = 64;
  localparam int FixW = 32;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_WIDTH = 2'd1,
    ST_NONFINITE = 2'd2
  } status_t;

  typedef enum logic {
    K_ENCODE = 1'b0,
    K_DECODE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    R_SLOTS = 2'd0,
    R_WHOLE = 2'd1,
    R_FRAC = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [5:0] slots;
    logic [5:0] whole;
    logic [5:0] frac;
  } cfg_t;
endpackage

// ===== sv/dfpc_encode.sv =====
module dfpc_encode #(
  parameter int MAX_SLOTS = dfpc_pkg::MaxSlots
) (
  input  logic [63:0]        real_in,
  input  dfpc_pkg::cfg_t     cfg,
  input  logic [5:0]         slots,
  output logic [MAX_SLOTS-1:0] fixed_out,
  output dfpc_pkg::status_t  status
);
  import dfpc_pkg::*;

  logic [10:0] expo;
  logic [52:0] mant;
  logic signed [13:0] shift;
  logic [6:0] n;
  logic [63:0] mag;
  logic [63:0] nmask;
  logic [63:0] smask;
  logic [63:0] sgn;
  logic [6:0] rs;

  always_comb begin
    expo = real_in[62:52];
    mant = {(expo != 11'd0), real_in[51:0]};
    shift = $signed({3'b000, (expo == 11'd0) ? 11'd1 : expo}) - 14'sd1075
            + $signed({8'd0, cfg.frac});
    n = {1'b0, cfg.whole} + {1'b0, cfg.frac};
    rs = 7'd0;
    if (shift >= 0) begin
      mag = (shift >= 14'sd32) ? 64'd0 : ({11'd0, mant} << shift[4:0]);
    end else if (shift <= -14'sd64) begin
      mag = 64'd0;
    end else begin
      rs = 7'(-shift);
      mag = {11'd0, mant} >> rs[5:0];
    end
    nmask = (n >= 7'd64) ? '1 : ((64'd1 << n[5:0]) - 64'd1);
    smask = (64'd1 << slots) - 64'd1;
    sgn = real_in[63] ? (64'd0 - (mag & nmask)) : (mag & nmask);
    status = ST_OK;
    fixed_out = '0;
    if (n > {1'b0, slots}) begin
      status = ST_WIDTH;
    end else if (expo == 11'h7ff) begin
      status = ST_NONFINITE;
    end else begin
      fixed_out = MAX_SLOTS'(sgn & smask);
    end
  end
endmodule

// ===== sv/dfpc_decode.sv =====
module dfpc_decode #(
  parameter int MAX_SLOTS = dfpc_pkg::MaxSlots
) (
  input  logic [MAX_SLOTS-1:0] fixed_in,
  input  logic [5:0]           slots,
  input  logic [5:0]           frac,
  output logic [63:0]          real_out
);
  import dfpc_pkg::*;

  localparam int LzW = $clog2(MAX_SLOTS + 1);
  localparam int IdxW = $clog2(MAX_SLOTS);

  logic [MAX_SLOTS-1:0] w;
  logic [MAX_SLOTS-1:0] smask;
  logic [IdxW-1:0] sign_pos;
  logic neg;
  logic [MAX_SLOTS-1:0] mag;
  logic [LzW-1:0] msb;
  logic found;
  logic [MAX_SLOTS-1:0] norm;
  logic [51:0] frc;
  logic [10:0] e;

  always_comb begin
    smask = MAX_SLOTS'((64'd1 << slots) - 64'd1);
    w = fixed_in & smask;
    sign_pos = IdxW'(slots - 6'd1);
    neg = w[sign_pos];
    mag = neg ? ((~w + 1'b1) & smask) : w;
    msb = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (mag[i]) begin
        msb = LzW'(i);
        found = 1'b1;
      end
    end
    norm = mag << (LzW'(MAX_SLOTS - 1) - msb);
    frc = '0;
    frc[51 -: (MAX_SLOTS - 1 > 0 ? MAX_SLOTS - 1 : 1)] = norm[MAX_SLOTS-2:0];
    e = 11'd1023 + 11'(msb) - 11'(frac);
    real_out = found ? {neg, e, frc} : 64'd0;
  end
endmodule

// ===== sv/double_fixed_point_converter.sv =====
// channel | direction | fields (low bit up)
// s_axis  | in        | tuser: kind; tdata: real_in[63:0], fixed_in[95:64]
// m_axis  | out       | tdata: fixed_out[31:0], real_out[95:32], status[97:96]
// cfg     | in        | wr_en, wr_index, wr_data
// one request per cycle while m_axis is not stalled, result in the cycle after accept
// output is held in a single result register
// s_axis_tready low only while the result register holds an untaken result
// reset is synchronous and empties the result register, registers to defaults
module double_fixed_point_converter #(
  parameter int MAX_SLOTS = dfpc_pkg::MaxSlots
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // real_in, fixed_in
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // fixed_out, real_out, status, zero pad
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [5:0]   wr_data
);
  import dfpc_pkg::*;

  cfg_t cfg;
  logic [5:0] slots;
  logic [MAX_SLOTS-1:0] enc_fix;
  status_t enc_st;
  logic [63:0] dec_real;
  logic [MAX_SLOTS-1:0] fin;
  logic take;
  logic [103:0] m_axis_tdata_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{slots: 6'd32, whole: 6'd16, frac: 6'd16};
    end else if (wr_en) begin
      case (wr_index)
        R_SLOTS: cfg.slots <= wr_data;
        R_WHOLE: cfg.whole <= wr_data;
        R_FRAC: cfg.frac <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg.slots == 6'd0) slots = 6'd1;
    else if (cfg.slots > 6'(MAX_SLOTS)) slots = 6'(MAX_SLOTS);
    else slots = cfg.slots;
  end

  assign fin = s_axis_tdata[64 +: MAX_SLOTS];

  dfpc_encode #(.MAX_SLOTS(MAX_SLOTS)) u_enc (
    .real_in(s_axis_tdata[63:0]), .cfg(cfg), .slots(slots),
    .fixed_out(enc_fix), .status(enc_st)
  );

  dfpc_decode #(.MAX_SLOTS(MAX_SLOTS)) u_dec (
    .fixed_in(fin), .slots(slots), .frac(cfg.frac), .real_out(dec_real)
  );

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    m_axis_tdata_next = '0;
    if (s_axis_tuser == K_ENCODE) begin
      m_axis_tdata_next[MAX_SLOTS-1:0] = enc_fix;
      m_axis_tdata_next[97:96] = enc_st;
    end else begin
      m_axis_tdata_next[95:32] = dec_real;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (s_axis_tready) m_axis_tvalid <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (take) m_axis_tdata <= m_axis_tdata_next;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result lost under stall");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    take |=> m_axis_tvalid) else $error("accepted request gave no result");
  a_st: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status_t'(m_axis_tdata[97:96]) != ST_OK |->
    m_axis_tdata[95:0] == 96'd0)
    else $error("error result carries data");
endmodule
